// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the integer accumulator ALU.
// Depends on nothing; bodies collapse to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising clock edge out of reset
`define IAA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check that an expression is never true out of reset
`define IAA_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define IAA_ASSERT(lbl, clk, rstn, prop, msg)
`define IAA_ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// File: src/iaa_pkg.sv
// Package of the integer accumulator ALU: widths, opcodes, constants and
// the request and result structures passed between the top level and engine.
package iaa_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned CntW  = $clog2(DataW);
  localparam int unsigned DigW  = 6;

  localparam logic [DataW-1:0] Radix     = DataW'(10);
  localparam logic [DigW-1:0]  DigitBase = DigW'(48);

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_REM   = 3'd5,
    OP_NEG   = 3'd6,
    OP_DIGIT = 3'd7
  } op_e;

  typedef struct packed {
    op_e                     opcode;
    logic signed [DataW-1:0] operand;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] acc_value;
    logic                    fault_flag;
    logic [DigW-1:0]         digit_code;
  } res_t;

endpackage

// File: src/iaa_addsub.sv
// Shared 64-bit adder/subtractor of the integer accumulator ALU.
// Depends on iaa_pkg for the data width.
module iaa_addsub (
  input  logic [iaa_pkg::DataW-1:0] a_i,
  input  logic [iaa_pkg::DataW-1:0] b_i,
  input  logic                      sub_i,
  output logic [iaa_pkg::DataW-1:0] sum_o,
  output logic                      cout_o
);

  logic [iaa_pkg::DataW-1:0] b_inv;

  // Invert the second operand and carry in one to subtract
  assign b_inv = b_i ^ {iaa_pkg::DataW{sub_i}};
  assign {cout_o, sum_o} = {1'b0, a_i} + {1'b0, b_inv}
                         + {{iaa_pkg::DataW{1'b0}}, sub_i};

endmodule

// File: src/iaa_engine.sv
// Sequencer and datapath of the integer accumulator ALU: holds the
// accumulator and flag, runs shift-add multiply and restoring divide through
// one shared adder (iaa_addsub). Depends on iaa_pkg.
module iaa_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  iaa_pkg::req_t req_i,
  input  logic          out_free_i,
  output logic          ready_o,
  output logic          res_load_o,
  output iaa_pkg::res_t res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ABSB,
    ST_ITER,
    ST_FIX,
    ST_DONE
  } state_e;

  state_e                      state_q, state_d;
  iaa_pkg::op_e                op_q, op_d;
  logic [iaa_pkg::DataW-1:0]   acc_q, acc_d;
  logic                        flag_q, flag_d;
  logic [iaa_pkg::DataW-1:0]   opd_q, opd_d;
  logic [iaa_pkg::DataW-1:0]   rem_q, rem_d;
  logic [iaa_pkg::DataW-1:0]   quo_q, quo_d;
  logic [iaa_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic                        sa_q, sa_d;
  logic                        sb_q, sb_d;
  logic [iaa_pkg::DigW-1:0]    dig_q, dig_d;

  logic [iaa_pkg::DataW-1:0]   add_a, add_b, add_sum;
  logic                        add_sub, add_cout;
  logic [iaa_pkg::DataW-1:0]   rem_shl;
  logic [iaa_pkg::DataW-1:0]   fix_val;
  logic                        fix_neg;
  logic                        is_mul;

  assign is_mul  = (op_q == iaa_pkg::OP_MUL);
  // Partial remainder shifted left with the next dividend bit
  assign rem_shl = {rem_q[iaa_pkg::DataW-2:0], quo_q[iaa_pkg::DataW-1]};

  // Pick the final value and its sign correction
  always_comb begin
    fix_val = quo_q;
    fix_neg = 1'b0;
    case (op_q)
      iaa_pkg::OP_MUL: begin
        fix_val = rem_q;
        fix_neg = 1'b0;
      end
      iaa_pkg::OP_DIV: begin
        fix_val = quo_q;
        fix_neg = sa_q ^ sb_q;
      end
      iaa_pkg::OP_REM: begin
        fix_val = rem_q;
        fix_neg = sa_q;
      end
      iaa_pkg::OP_DIGIT: begin
        fix_val = quo_q;
        fix_neg = sa_q;
      end
      default: begin
        fix_val = quo_q;
        fix_neg = 1'b0;
      end
    endcase
  end

  // Steer the shared adder by state
  always_comb begin
    add_a   = acc_q;
    add_b   = opd_q;
    add_sub = 1'b0;
    case (state_q)
      ST_EXEC: begin
        case (op_q)
          iaa_pkg::OP_SUB: add_sub = 1'b1;
          iaa_pkg::OP_NEG, iaa_pkg::OP_DIV, iaa_pkg::OP_REM, iaa_pkg::OP_DIGIT: begin
            add_a   = '0;
            add_b   = acc_q;
            add_sub = (op_q == iaa_pkg::OP_NEG) ? 1'b1 : acc_q[iaa_pkg::DataW-1];
          end
          default: add_sub = 1'b0;
        endcase
      end
      ST_ABSB: begin
        add_a   = '0;
        add_b   = opd_q;
        add_sub = opd_q[iaa_pkg::DataW-1];
      end
      ST_ITER: begin
        if (is_mul) begin
          add_a   = rem_q;
          add_b   = quo_q & {iaa_pkg::DataW{opd_q[0]}};
          add_sub = 1'b0;
        end else begin
          add_a   = rem_shl;
          add_b   = opd_q;
          add_sub = 1'b1;
        end
      end
      ST_FIX: begin
        add_a   = '0;
        add_b   = fix_val;
        add_sub = fix_neg;
      end
      default: add_sub = 1'b0;
    endcase
  end

  iaa_addsub u_addsub (
    .a_i    (add_a),
    .b_i    (add_b),
    .sub_i  (add_sub),
    .sum_o  (add_sum),
    .cout_o (add_cout)
  );

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    acc_d   = acc_q;
    flag_d  = flag_q;
    opd_d   = opd_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    sa_d    = sa_q;
    sb_d    = sb_q;
    dig_d   = dig_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d    = req_i.opcode;
          opd_d   = req_i.operand;
          dig_d   = '0;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        case (op_q)
          iaa_pkg::OP_LOAD: acc_d = opd_q;
          iaa_pkg::OP_ADD, iaa_pkg::OP_NEG: begin
            acc_d  = add_sum;
            flag_d = 1'b0;
          end
          iaa_pkg::OP_SUB: acc_d = add_sum;
          iaa_pkg::OP_MUL: begin
            rem_d   = '0;
            quo_d   = acc_q;
            cnt_d   = '0;
            state_d = ST_ITER;
          end
          iaa_pkg::OP_DIV, iaa_pkg::OP_REM: begin
            if (opd_q == '0) begin
              flag_d = 1'b1;
            end else begin
              quo_d   = add_sum;
              rem_d   = '0;
              sa_d    = acc_q[iaa_pkg::DataW-1];
              sb_d    = opd_q[iaa_pkg::DataW-1];
              state_d = ST_ABSB;
            end
          end
          iaa_pkg::OP_DIGIT: begin
            quo_d   = add_sum;
            rem_d   = '0;
            sa_d    = acc_q[iaa_pkg::DataW-1];
            sb_d    = 1'b0;
            opd_d   = iaa_pkg::Radix;
            cnt_d   = '0;
            state_d = ST_ITER;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_ABSB: begin
        opd_d   = add_sum;
        cnt_d   = '0;
        state_d = ST_ITER;
      end
      ST_ITER: begin
        if (is_mul) begin
          rem_d = add_sum;
          quo_d = {quo_q[iaa_pkg::DataW-2:0], 1'b0};
          opd_d = {1'b0, opd_q[iaa_pkg::DataW-1:1]};
        end else begin
          rem_d = add_cout ? add_sum : rem_shl;
          quo_d = {quo_q[iaa_pkg::DataW-2:0], add_cout};
        end
        cnt_d = cnt_q + iaa_pkg::CntW'(1);
        if (cnt_q == '1) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        acc_d = add_sum;
        if (op_q == iaa_pkg::OP_DIGIT) begin
          // Remainder is below ten; its sign follows the dividend
          dig_d = sa_q ? (iaa_pkg::DigitBase + {2'b00, rem_q[3:0]})
                       : (iaa_pkg::DigitBase - {2'b00, rem_q[3:0]});
        end else begin
          flag_d = 1'b0;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold control state and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= '0;
      flag_q  <= 1'b0;
      dig_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      flag_q  <= flag_d;
      dig_q   <= dig_d;
    end
  end

  // Advance working registers
  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    opd_q <= opd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
    sa_q  <= sa_d;
    sb_q  <= sb_d;
  end

  assign ready_o          = (state_q == ST_IDLE);
  assign res_load_o       = (state_q == ST_DONE) && out_free_i;
  assign res_o.acc_value  = acc_q;
  assign res_o.fault_flag = flag_q;
  assign res_o.digit_code = dig_q;

endmodule

// File: src/integer_accumulator_alu.sv
// Top level of the integer accumulator ALU: handshake and output register
// around iaa_engine. Depends on iaa_pkg and assert_macros.svh.
//
// One item is worked on at a time; in_ready_o is low from acceptance until
// the result is moved into the output register. Load, add, subtract, negate
// and a divide or remainder by zero pass from ST_EXEC straight to ST_DONE;
// multiply and digit extract run ST_EXEC, ST_ITER and ST_FIX; divide and
// remainder add ST_ABSB after ST_EXEC, which takes the magnitude of the
// divisor. ST_ITER holds the 64 steps of shift-add multiply and restoring
// divide, one bit per cycle through the single shared 64-bit adder, and
// ST_FIX writes the result back, with any sign correction, on the same
// adder. in_ready_o returns in the same cycle that out_valid_o rises, as
// the result is loaded, so a new item can be accepted then. A result still
// waiting in the output register holds the engine until it is taken.
module integer_accumulator_alu (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [2:0]                       opcode_i,
  input  logic signed [iaa_pkg::DataW-1:0] operand_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [iaa_pkg::DataW-1:0] acc_value_o,
  output logic                             fault_flag_o,
  output logic [iaa_pkg::DigW-1:0]         digit_code_o
);

  `include "assert_macros.svh"

  iaa_pkg::req_t req;
  iaa_pkg::res_t res;
  iaa_pkg::res_t out_q;
  logic          out_valid_q, out_valid_d;
  logic          eng_ready, res_load, out_free, start;

  assign req.opcode  = iaa_pkg::op_e'(opcode_i);
  assign req.operand = operand_i;
  assign start       = in_valid_i && eng_ready;
  assign out_free    = !out_valid_q || out_ready_i;

  iaa_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (req),
    .out_free_i (out_free),
    .ready_o    (eng_ready),
    .res_load_o (res_load),
    .res_o      (res)
  );

  // Load the output register from the engine, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign in_ready_o   = eng_ready;
  assign out_valid_o  = out_valid_q;
  assign acc_value_o  = out_q.acc_value;
  assign fault_flag_o = out_q.fault_flag;
  assign digit_code_o = out_q.digit_code;

  // One item in flight: the engine is busy right after an acceptance
  `IAA_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "engine still ready after accepting an item")
  // A new result only appears after the engine was working on an item
  `IAA_ASSERT(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o) |-> $past(!in_ready_o), "result produced without an item in work")
  // Digit codes are zero or stay in the character window 39 to 57
  `IAA_ASSERT_NEVER(a_digit_range, clk_i, rst_ni, out_valid_o && (digit_code_o != 6'd0) && ((digit_code_o < 6'd39) || (digit_code_o > 6'd57)), "digit code out of range")

endmodule
